### rtl/core/assert_macros.svh
// Assertion macros used by the checker module of the expression tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk_i outside reset.
`define ETU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising edge of clk_i, reset included.
`define ETU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/etu_pkg.sv
// Shared types, constants and character classes of the expression tokenizer.
package etu_pkg;

  localparam int MaxTextLen  = 65536;
  localparam int MaxTokenLen = 64;

  localparam int CharW     = 8;
  localparam int KindW     = 4;
  localparam int ErrW      = 2;
  localparam int PosW      = 16;
  localparam int LenW      = 7;
  localparam int TextPosW  = $clog2(MaxTextLen + 1);
  localparam int TokLenW   = $clog2(MaxTokenLen + 1);

  localparam int QueueDepth = 4;
  localparam int QueueAddrW = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [CharW-1:0] ChNul    = 8'h00;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChTab    = 8'h09;
  localparam logic [CharW-1:0] ChCr     = 8'h0D;
  localparam logic [CharW-1:0] ChDot    = 8'h2E;
  localparam logic [CharW-1:0] ChMinus  = 8'h2D;
  localparam logic [CharW-1:0] ChOpen   = 8'h28;
  localparam logic [CharW-1:0] ChClose  = 8'h29;
  localparam logic [CharW-1:0] ChPlus   = 8'h2B;
  localparam logic [CharW-1:0] ChStar   = 8'h2A;
  localparam logic [CharW-1:0] ChSlash  = 8'h2F;
  localparam logic [CharW-1:0] ChComma  = 8'h2C;
  localparam logic [CharW-1:0] ChZero   = 8'h30;
  localparam logic [CharW-1:0] ChNine   = 8'h39;
  localparam logic [CharW-1:0] ChLowA   = 8'h61;
  localparam logic [CharW-1:0] ChLowZ   = 8'h7A;
  localparam logic [CharW-1:0] ChUpA    = 8'h41;
  localparam logic [CharW-1:0] ChUpZ    = 8'h5A;

  typedef enum logic [KindW-1:0] {
    KIND_OPEN   = 4'd0,
    KIND_CLOSE  = 4'd1,
    KIND_NUMBER = 4'd2,
    KIND_PLUS   = 4'd3,
    KIND_MINUS  = 4'd4,
    KIND_MULT   = 4'd5,
    KIND_DIV    = 4'd6,
    KIND_IDENT  = 4'd7,
    KIND_COMMA  = 4'd8,
    KIND_END    = 4'd9
  } token_kind_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE    = 2'd0,
    ERR_NUMBER  = 2'd1,
    ERR_UNKNOWN = 2'd2,
    ERR_LONG    = 2'd3
  } error_code_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_IDENT  = 2'd2
  } scan_mode_e;

  typedef struct packed {
    scan_mode_e          mode;
    logic                sign_allowed;
    logic [1:0]          dot_count;
    logic                last_was_dot;
    logic [PosW-1:0]     token_start;
    logic [TokLenW-1:0]  token_len;
    logic [TextPosW-1:0] text_pos;
    logic                halted;
  } scan_state_t;

  typedef struct packed {
    token_kind_e     kind;
    error_code_e     err;
    logic [PosW-1:0] start;
    logic [LenW-1:0] len;
    logic            last;
  } result_t;

  // Up to two results per character, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_results_t;

  function automatic scan_state_t reset_state();
    scan_state_t s;
    s              = '0;
    s.mode         = MODE_IDLE;
    s.sign_allowed = 1'b1;
    return s;
  endfunction

  function automatic logic is_digit(logic [CharW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_alpha(logic [CharW-1:0] c);
    return ((c >= ChLowA) && (c <= ChLowZ)) || ((c >= ChUpA) && (c <= ChUpZ));
  endfunction

  function automatic logic is_space(logic [CharW-1:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

endpackage

### rtl/core/expression_tokenizer_unit.sv
// Top level of the streaming arithmetic expression tokenizer.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         in_valid_i / in_stall_o   character_i, end_of_text_i
//   result    out        out_valid_o / out_stall_i token_kind_o, error_code_o,
//                                                  start_pos_o, token_length_o, last_o
//
// A character transaction is registered on acceptance and decided once the queue has
// room for two results; its results (none, one or two) enter a four-entry result queue.
// One character is taken per cycle while the queue holds at most two results, so the
// sustained rate is one character per cycle, bounded by one result per cycle.
// Reset is asynchronous and active low; it clears the scanner state and empties the queue.
// A stall on the result side fills the queue and then stalls the input side.
module expression_tokenizer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [etu_pkg::CharW-1:0]     character_i,
  input  logic                          end_of_text_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [etu_pkg::KindW-1:0]     token_kind_o,
  output logic [etu_pkg::ErrW-1:0]      error_code_o,
  output logic [etu_pkg::PosW-1:0]      start_pos_o,
  output logic [etu_pkg::LenW-1:0]      token_length_o,
  output logic                          last_o
);

  // Input register: holds one character transaction until the queue can take
  // everything it may produce.
  logic                      in_valid_q, in_valid_d;
  logic [etu_pkg::CharW-1:0] char_q;
  logic                      eot_q;
  logic                      in_accept;
  logic                      process;

  // Scanner state, updated once per processed character.
  etu_pkg::scan_state_t  state_q, state_d, step_state;
  etu_pkg::step_results_t step_res, push;

  logic             q_room;
  logic             q_valid;
  etu_pkg::result_t q_head;

  // The held character is processed as soon as two queue slots are free.
  assign process    = in_valid_q && q_room;
  assign in_stall_o = in_valid_q && !q_room;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (process) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      char_q <= character_i;
      eot_q  <= end_of_text_i;
    end
  end

  etu_step u_step (
    .state_i       (state_q),
    .character_i   (char_q),
    .end_of_text_i (eot_q),
    .state_o       (step_state),
    .results_o     (step_res)
  );

  assign state_d = process ? step_state : state_q;

  // Nothing enters the queue unless the character is really processed.
  always_comb begin
    push = step_res;
    if (!process) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= etu_pkg::reset_state();
    end else begin
      in_valid_q <= in_valid_d;
      state_q    <= state_d;
    end
  end

  etu_result_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (q_valid && !out_stall_i),
    .valid_o (q_valid),
    .room_o  (q_room),
    .head_o  (q_head)
  );

  assign out_valid_o    = q_valid;
  assign token_kind_o   = q_head.kind;
  assign error_code_o   = q_head.err;
  assign start_pos_o    = q_head.start;
  assign token_length_o = q_head.len;
  assign last_o         = q_head.last;

endmodule

### rtl/core/etu_step.sv
// Per-character scanner decision: next scan state and the results it causes.
module etu_step (
  input  etu_pkg::scan_state_t         state_i,
  input  logic [etu_pkg::CharW-1:0]    character_i,
  input  logic                         end_of_text_i,
  output etu_pkg::scan_state_t         state_o,
  output etu_pkg::step_results_t       results_o
);

  etu_pkg::scan_state_t nxt;
  etu_pkg::result_t     pend_res;
  etu_pkg::result_t     char_res;
  logic                 pend_vld;
  logic                 char_vld;
  logic                 eot;
  logic                 malformed;
  logic                 sign_now;
  logic [etu_pkg::PosW-1:0] pos;
  logic [etu_pkg::LenW-1:0] cur_len;

  assign eot       = end_of_text_i || (character_i == etu_pkg::ChNul);
  assign malformed = (state_i.dot_count > 2'd1) || state_i.last_was_dot;
  assign pos       = state_i.text_pos[etu_pkg::PosW-1:0];
  assign cur_len   = etu_pkg::LenW'(state_i.token_len);

  always_comb begin
    nxt      = state_i;
    pend_vld = 1'b0;
    char_vld = 1'b0;
    pend_res = '0;
    char_res = '0;
    sign_now = state_i.sign_allowed;

    if (state_i.halted) begin
      if (eot) begin
        nxt = etu_pkg::reset_state();
      end
    end else if (eot) begin
      // Close the pending token, then the end token unless the number was bad.
      if (state_i.mode == etu_pkg::MODE_NUMBER) begin
        pend_vld = 1'b1;
        pend_res.kind  = malformed ? etu_pkg::KIND_END : etu_pkg::KIND_NUMBER;
        pend_res.err   = malformed ? etu_pkg::ERR_NUMBER : etu_pkg::ERR_NONE;
        pend_res.start = state_i.token_start;
        pend_res.len   = cur_len;
        char_vld       = !malformed;
      end else if (state_i.mode == etu_pkg::MODE_IDENT) begin
        pend_vld = 1'b1;
        pend_res.kind  = etu_pkg::KIND_IDENT;
        pend_res.err   = etu_pkg::ERR_NONE;
        pend_res.start = state_i.token_start;
        pend_res.len   = cur_len;
        char_vld       = 1'b1;
      end else begin
        char_vld = 1'b1;
      end
      char_res.kind  = etu_pkg::KIND_END;
      char_res.err   = etu_pkg::ERR_NONE;
      char_res.start = pos;
      char_res.len   = '0;
      nxt = etu_pkg::reset_state();
    end else if (state_i.text_pos >= etu_pkg::TextPosW'(etu_pkg::MaxTextLen)) begin
      char_vld       = 1'b1;
      char_res.kind  = etu_pkg::KIND_END;
      char_res.err   = etu_pkg::ERR_LONG;
      char_res.start = pos;
      char_res.len   = '0;
      nxt.halted     = 1'b1;
    end else begin
      nxt.text_pos = state_i.text_pos + 1'b1;
      if ((state_i.mode == etu_pkg::MODE_NUMBER) &&
          (etu_pkg::is_digit(character_i) || (character_i == etu_pkg::ChDot))) begin
        if (state_i.token_len >= etu_pkg::TokLenW'(etu_pkg::MaxTokenLen)) begin
          char_vld       = 1'b1;
          char_res.kind  = etu_pkg::KIND_END;
          char_res.err   = etu_pkg::ERR_LONG;
          char_res.start = state_i.token_start;
          char_res.len   = cur_len;
          nxt.halted     = 1'b1;
        end else begin
          nxt.token_len = state_i.token_len + 1'b1;
          if (character_i == etu_pkg::ChDot) begin
            if (state_i.dot_count < 2'd2) begin
              nxt.dot_count = state_i.dot_count + 2'd1;
            end
            nxt.last_was_dot = 1'b1;
          end else begin
            nxt.last_was_dot = 1'b0;
          end
        end
      end else if ((state_i.mode == etu_pkg::MODE_IDENT) && etu_pkg::is_alpha(character_i)) begin
        if (state_i.token_len >= etu_pkg::TokLenW'(etu_pkg::MaxTokenLen)) begin
          char_vld       = 1'b1;
          char_res.kind  = etu_pkg::KIND_END;
          char_res.err   = etu_pkg::ERR_LONG;
          char_res.start = state_i.token_start;
          char_res.len   = cur_len;
          nxt.halted     = 1'b1;
        end else begin
          nxt.token_len = state_i.token_len + 1'b1;
        end
      end else begin
        // The character ends any pending token.
        if (state_i.mode != etu_pkg::MODE_IDLE) begin
          pend_vld       = 1'b1;
          pend_res.start = state_i.token_start;
          pend_res.len   = cur_len;
          pend_res.err   = etu_pkg::ERR_NONE;
          pend_res.kind  = (state_i.mode == etu_pkg::MODE_NUMBER) ? etu_pkg::KIND_NUMBER
                                                                   : etu_pkg::KIND_IDENT;
          nxt.mode       = etu_pkg::MODE_IDLE;
          sign_now       = 1'b0;
          nxt.sign_allowed = 1'b0;
        end
        if ((state_i.mode == etu_pkg::MODE_NUMBER) && malformed) begin
          pend_res.kind = etu_pkg::KIND_END;
          pend_res.err  = etu_pkg::ERR_NUMBER;
          nxt.sign_allowed = state_i.sign_allowed;
          nxt.halted    = 1'b1;
        end else if (etu_pkg::is_space(character_i)) begin
          // Spaces only separate tokens.
        end else if (etu_pkg::is_digit(character_i) ||
                     ((character_i == etu_pkg::ChMinus) && sign_now)) begin
          nxt.mode         = etu_pkg::MODE_NUMBER;
          nxt.token_start  = pos;
          nxt.token_len    = etu_pkg::TokLenW'(1);
          nxt.dot_count    = 2'd0;
          nxt.last_was_dot = 1'b0;
        end else if (etu_pkg::is_alpha(character_i)) begin
          nxt.mode        = etu_pkg::MODE_IDENT;
          nxt.token_start = pos;
          nxt.token_len   = etu_pkg::TokLenW'(1);
        end else begin
          char_vld       = 1'b1;
          char_res.err   = etu_pkg::ERR_NONE;
          char_res.start = pos;
          char_res.len   = etu_pkg::LenW'(1);
          nxt.sign_allowed = 1'b0;
          case (character_i)
            etu_pkg::ChOpen: begin
              char_res.kind    = etu_pkg::KIND_OPEN;
              nxt.sign_allowed = 1'b1;
            end
            etu_pkg::ChClose: char_res.kind = etu_pkg::KIND_CLOSE;
            etu_pkg::ChPlus:  char_res.kind = etu_pkg::KIND_PLUS;
            etu_pkg::ChMinus: char_res.kind = etu_pkg::KIND_MINUS;
            etu_pkg::ChStar:  char_res.kind = etu_pkg::KIND_MULT;
            etu_pkg::ChSlash: char_res.kind = etu_pkg::KIND_DIV;
            etu_pkg::ChComma: begin
              char_res.kind    = etu_pkg::KIND_COMMA;
              nxt.sign_allowed = 1'b1;
            end
            default: begin
              char_res.kind    = etu_pkg::KIND_END;
              char_res.err     = etu_pkg::ERR_UNKNOWN;
              nxt.sign_allowed = sign_now;
              nxt.halted       = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_comb begin
    results_o.count = {1'b0, pend_vld} + {1'b0, char_vld};
    results_o.first = pend_vld ? pend_res : char_res;
    results_o.first.last  = !(pend_vld && char_vld);
    results_o.second      = char_res;
    results_o.second.last = 1'b1;
  end

  assign state_o = nxt;

endmodule

### rtl/core/etu_result_queue.sv
// Small result queue: takes up to two results a cycle, hands out one a cycle.
module etu_result_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  etu_pkg::step_results_t push_i,
  input  logic                   pop_i,
  output logic                   valid_o,
  output logic                   room_o,
  output etu_pkg::result_t       head_o
);

  etu_pkg::result_t entries_q [etu_pkg::QueueDepth];
  logic [etu_pkg::QueueAddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [etu_pkg::QueueAddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [etu_pkg::QueueCntW-1:0]  count_q, count_d;
  logic [etu_pkg::QueueAddrW-1:0] wr_ptr_next;

  assign wr_ptr_next = wr_ptr_q + 1'b1;
  assign valid_o     = (count_q != '0);
  assign room_o      = (count_q <= etu_pkg::QueueCntW'(etu_pkg::QueueDepth - 2));
  assign head_o      = entries_q[rd_ptr_q];

  assign wr_ptr_d = wr_ptr_q + etu_pkg::QueueAddrW'(push_i.count);
  assign rd_ptr_d = rd_ptr_q + etu_pkg::QueueAddrW'(pop_i);
  assign count_d  = count_q + etu_pkg::QueueCntW'(push_i.count)
                            - etu_pkg::QueueCntW'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      entries_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      entries_q[wr_ptr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### rtl/core/etu_checker.sv
// Port-level checker for the expression tokenizer, bound to the top level.
`include "assert_macros.svh"

module etu_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [etu_pkg::KindW-1:0] token_kind_o,
  input logic [etu_pkg::ErrW-1:0]  error_code_o,
  input logic [etu_pkg::PosW-1:0]  start_pos_o,
  input logic [etu_pkg::LenW-1:0]  token_length_o,
  input logic                      last_o
);

  logic single_char_kind;

  assign single_char_kind = (token_kind_o == etu_pkg::KIND_OPEN)  ||
                            (token_kind_o == etu_pkg::KIND_CLOSE) ||
                            (token_kind_o == etu_pkg::KIND_PLUS)  ||
                            (token_kind_o == etu_pkg::KIND_MINUS) ||
                            (token_kind_o == etu_pkg::KIND_MULT)  ||
                            (token_kind_o == etu_pkg::KIND_DIV)   ||
                            (token_kind_o == etu_pkg::KIND_COMMA);

  `ETU_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o) && $stable(error_code_o) && $stable(start_pos_o) && $stable(token_length_o) && $stable(last_o), "stalled result changed")
  `ETU_ASSERT(a_err_only_end, out_valid_o && (token_kind_o != etu_pkg::KIND_END) |-> (error_code_o == etu_pkg::ERR_NONE), "error code on a non-end token")
  `ETU_ASSERT(a_single_len, out_valid_o && single_char_kind |-> (token_length_o == etu_pkg::LenW'(1)) && last_o, "operator token not one character or not last")
  `ETU_ASSERT(a_len_max, out_valid_o |-> (token_length_o <= etu_pkg::LenW'(etu_pkg::MaxTokenLen)), "token length beyond limit")
  `ETU_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind expression_tokenizer_unit etu_checker u_etu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .token_kind_o   (token_kind_o),
  .error_code_o   (error_code_o),
  .start_pos_o    (start_pos_o),
  .token_length_o (token_length_o),
  .last_o         (last_o)
);
